>>> rtl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants of the TGA stream decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

	localparam int unsigned TGA_QUEUE_DEPTH = 4;
	localparam int unsigned RUN_W = 8;

	localparam logic [2:0] STAT_HDR_OK      = 3'd0;
	localparam logic [2:0] STAT_RUN         = 3'd1;
	localparam logic [2:0] STAT_COMPLETE    = 3'd2;
	localparam logic [2:0] STAT_PARTIAL     = 3'd3;
	localparam logic [2:0] STAT_UNSUPPORTED = 3'd4;
	localparam logic [2:0] STAT_TRUNCATED   = 3'd5;

	localparam logic [7:0] IMG_TRUE_COLOUR     = 8'd2;
	localparam logic [7:0] IMG_GREY            = 8'd3;
	localparam logic [7:0] IMG_RLE_TRUE_COLOUR = 8'd10;

	localparam logic [7:0] DEPTH_MIN = 8'd8;
	localparam logic [7:0] DEPTH_MAX = 8'd32;

	localparam logic [4:0] HP_TYPE      = 5'd2;
	localparam logic [4:0] HP_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HP_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HP_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HP_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HP_DEPTH     = 5'd16;
	localparam logic [4:0] HP_DESC      = 5'd17;

	localparam int unsigned PKT_REPEAT_BIT = 7;
	localparam int unsigned DESC_TOP_BIT   = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tga_byte_req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      pixel_value;
		logic [RUN_W-1:0] run_count;
		logic [15:0]      start_column;
		logic [15:0]      start_row;
		logic [7:0]       image_type;
		logic [7:0]       bits_per_pixel;
		logic [15:0]      image_width;
		logic [15:0]      image_height;
	} tga_result_req_t;

	// classified request, position still to be filled in
	typedef struct packed {
		logic [2:0]       status;
		logic [31:0]      pixel;
		logic [RUN_W-1:0] run;
		logic [7:0]       img_type;
		logic [7:0]       depth;
		logic [15:0]      width;
		logic [15:0]      height;
		logic             flip;
	} tga_item_t;

	typedef struct packed {
		logic      v0;
		logic      v1;
		tga_item_t i0;
		tga_item_t i1;
	} tga_push_t;

	typedef struct packed {
		logic      valid;
		tga_item_t item;
	} tga_head_t;

endpackage

>>> rtl/tga_image_stream_decoder.sv
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// TGA file to pixel-run stream decoder, one file byte per request.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while file_stall is low and returns status and
// pixel-run requests, at most one per cycle, through the request queue and the
// output register. A parser front end reads the 18-byte header, unpacks raw or
// RLE pixels and counts down the pixels owed; it feeds a QUEUE_DEPTH-entry
// request queue and stalls the byte side whenever fewer than two entries are
// free. The back end stamps each run with its column and destination row from
// a single add-and-compare per run, except for a repeat run that wraps more
// than one row (images narrower than 128 columns): that run occupies the back
// end's bit-serial width divider, and no new request is taken until it is done.
// The queue absorbs an isolated one; a stream of such runs stalls the byte side.
// Raw images and literal RLE packets sustain one byte per cycle without stalls.
module tga_image_stream_decoder import tga_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = TGA_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            file_valid,
	output logic            file_stall,
	input  tga_byte_req_t   file_req,
	output logic            result_valid,
	input  logic            result_stall,
	output tga_result_req_t result_req
);

	tga_push_t push;
	tga_head_t head;
	logic      room;
	logic      pop;

	tga_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_stall (file_stall),
		.file_req   (file_req),
		.room       (room),
		.push       (push)
	);

	tga_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.room   (room)
	);

	tga_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_req   (result_req)
	);

endmodule

>>> rtl/tga_front.sv
// ----------------------------------------------------------------------------
// tga_front
// Byte parser: header capture, RLE packet decode, pixel assembly, pixel
// budget and status classification. Pushes up to two requests per byte.
// ----------------------------------------------------------------------------
module tga_front import tga_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          file_valid,
	output logic          file_stall,
	input  tga_byte_req_t file_req,
	input  logic          room,
	output tga_push_t     push
);

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_PACKET = 4'b0010,
		PH_PIXEL  = 4'b0100,
		PH_DONE   = 4'b1000
	} tga_phase_t;

	tga_phase_t  phase_q, phase_d, phase_n;
	logic [4:0]  hpos_q, hpos_d, hpos_n;
	logic [7:0]  type_q, type_d;
	logic [7:0]  depth_q, depth_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        flip_q, flip_d;
	logic [RUN_W-1:0] pkt_left_q, pkt_left_d, pkt_left_dec;
	logic        pkt_rep_q, pkt_rep_d;
	logic [1:0]  comp_q, comp_d, comp_n, comp_inc;
	logic [31:0] asm_q, asm_d, asm_n, asm_add, pix_sw;
	logic [31:0] total_q;
	logic [31:0] remain_q, remain_d, remain_run;

	logic            accept;
	logic [7:0]      b;
	logic            hdr_end, hdr_bad, hdr_empty, is_rle;
	logic [2:0]      mode;
	logic            pix_done, rep_run, clip;
	logic [RUN_W-1:0] run_n;
	logic            a_v, b_v, l_v;
	logic [2:0]      a_st, l_st;
	logic [31:0]     a_pix;
	logic [RUN_W-1:0] a_run;
	tga_item_t       base;

	assign file_stall = !room;
	assign accept     = file_valid && room;
	assign b          = file_req.data_byte;

	// header register capture
	always_comb begin
		type_d   = type_q;
		depth_d  = depth_q;
		width_d  = width_q;
		height_d = height_q;
		flip_d   = flip_q;
		if (phase_q == PH_HEADER) begin
			case (hpos_q)
				HP_TYPE:      type_d = b;
				HP_WIDTH_LO:  width_d = {width_q[15:8], b};
				HP_WIDTH_HI:  width_d = {b, width_q[7:0]};
				HP_HEIGHT_LO: height_d = {height_q[15:8], b};
				HP_HEIGHT_HI: height_d = {b, height_q[7:0]};
				HP_DEPTH:     depth_d = b;
				HP_DESC:      flip_d = !b[DESC_TOP_BIT];
				default: ;
			endcase
		end
	end

	assign hdr_end   = (hpos_q == HP_DESC);
	assign hdr_bad   = !(type_q == IMG_TRUE_COLOUR || type_q == IMG_GREY ||
		type_q == IMG_RLE_TRUE_COLOUR) || depth_q < DEPTH_MIN || depth_q > DEPTH_MAX;
	assign hdr_empty = (width_q == 16'd0) || (height_q == 16'd0);
	assign is_rle    = (type_q == IMG_RLE_TRUE_COLOUR);

	// pixel assembly
	assign mode     = depth_q[5:3];
	assign comp_inc = comp_q + 2'd1;
	assign pix_done = ({1'b0, comp_inc} >= mode) || (comp_inc == 2'd0);
	assign asm_add  = {24'd0, b} << {comp_q, 3'b000};
	assign asm_d    = asm_q | asm_add;
	assign pix_sw   = (mode >= 3'd3) ?
		{asm_d[31:24], asm_d[7:0], asm_d[15:8], asm_d[23:16]} : asm_d;

	// run length, clipped to the pixels still owed
	assign rep_run      = is_rle && pkt_rep_q;
	assign clip         = remain_q < 32'(pkt_left_q);
	assign run_n        = rep_run ? (clip ? remain_q[RUN_W-1:0] : pkt_left_q) :
		RUN_W'(1);
	assign remain_run   = remain_q - 32'(run_n);
	assign pkt_left_dec = pkt_left_q - RUN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		hpos_d     = hpos_q;
		comp_d     = comp_q;
		asm_n      = asm_q;
		pkt_left_d = pkt_left_q;
		pkt_rep_d  = pkt_rep_q;
		remain_d   = remain_q;
		a_v        = 1'b0;
		a_st       = STAT_HDR_OK;
		a_pix      = 32'd0;
		a_run      = '0;
		b_v        = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_end) begin
					hpos_d     = 5'd0;
					comp_d     = 2'd0;
					asm_n      = 32'd0;
					pkt_left_d = '0;
					pkt_rep_d  = 1'b0;
					remain_d   = total_q;
					a_v        = 1'b1;
					if (hdr_bad) begin
						a_st    = STAT_UNSUPPORTED;
						phase_d = PH_DONE;
					end else if (hdr_empty) begin
						b_v     = 1'b1;
						phase_d = PH_DONE;
					end else begin
						phase_d = is_rle ? PH_PACKET : PH_PIXEL;
					end
				end else begin
					hpos_d = hpos_q + 5'd1;
				end
			end
			PH_PACKET: begin
				pkt_rep_d  = b[PKT_REPEAT_BIT];
				pkt_left_d = {1'b0, b[6:0]} + RUN_W'(1);
				comp_d     = 2'd0;
				asm_n      = 32'd0;
				phase_d    = PH_PIXEL;
			end
			PH_PIXEL: begin
				comp_d = comp_inc;
				asm_n  = asm_d;
				if (pix_done) begin
					comp_d   = 2'd0;
					asm_n    = 32'd0;
					a_v      = 1'b1;
					a_st     = STAT_RUN;
					a_pix    = pix_sw;
					a_run    = run_n;
					remain_d = remain_run;
					if (rep_run) begin
						pkt_left_d = '0;
						phase_d    = PH_PACKET;
					end else if (is_rle) begin
						pkt_left_d = pkt_left_dec;
						phase_d    = (pkt_left_dec != '0) ? PH_PIXEL : PH_PACKET;
					end
					if (remain_run == 32'd0) begin
						b_v     = 1'b1;
						phase_d = PH_DONE;
					end
				end
			end
			PH_DONE: ;
			default: phase_d = PH_HEADER;
		endcase
	end

	// end of file
	always_comb begin
		phase_n = phase_d;
		hpos_n  = hpos_d;
		comp_n  = comp_d;
		l_v     = 1'b0;
		l_st    = STAT_TRUNCATED;
		if (file_req.last_byte) begin
			if (phase_d == PH_HEADER) begin
				l_v = 1'b1;
			end else if (phase_d == PH_PACKET || phase_d == PH_PIXEL) begin
				l_v  = 1'b1;
				l_st = (type_d == IMG_RLE_TRUE_COLOUR) ? STAT_PARTIAL : STAT_TRUNCATED;
			end
			phase_n = PH_HEADER;
			hpos_n  = 5'd0;
			comp_n  = 2'd0;
		end
	end

	always_comb begin
		base.status   = STAT_HDR_OK;
		base.pixel    = 32'd0;
		base.run      = '0;
		base.img_type = type_d;
		base.depth    = depth_d;
		base.width    = width_d;
		base.height   = height_d;
		base.flip     = flip_d;
		push.i0       = base;
		push.i1       = base;
		if (a_v) begin
			push.i0.status = a_st;
			push.i0.pixel  = a_pix;
			push.i0.run    = a_run;
			push.i1.status = b_v ? STAT_COMPLETE : l_st;
			push.v0        = accept;
			push.v1        = accept && (b_v || l_v);
		end else begin
			push.i0.status = l_st;
			push.v0        = accept && l_v;
			push.v1        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hpos_q     <= 5'd0;
			type_q     <= 8'd0;
			depth_q    <= 8'd0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			flip_q     <= 1'b0;
			pkt_left_q <= '0;
			pkt_rep_q  <= 1'b0;
			comp_q     <= 2'd0;
			asm_q      <= 32'd0;
			total_q    <= 32'd0;
			remain_q   <= 32'd0;
		end else if (accept) begin
			phase_q    <= phase_n;
			hpos_q     <= hpos_n;
			type_q     <= type_d;
			depth_q    <= depth_d;
			width_q    <= width_d;
			height_q   <= height_d;
			flip_q     <= flip_d;
			pkt_left_q <= pkt_left_d;
			pkt_rep_q  <= pkt_rep_d;
			comp_q     <= comp_n;
			asm_q      <= file_req.last_byte ? 32'd0 : asm_n;
			remain_q   <= remain_d;
			if (phase_q == PH_HEADER && hpos_q == HP_DEPTH) begin
				total_q <= 32'(width_q) * 32'(height_q);
			end
		end
	end

endmodule

>>> rtl/tga_queue.sv
// ----------------------------------------------------------------------------
// tga_queue
// Short request queue between parser and position unit. Takes up to two
// requests per cycle, hands out one.
// ----------------------------------------------------------------------------
module tga_queue import tga_pkg::*; #(
	parameter int unsigned DEPTH = TGA_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tga_push_t push,
	input  logic      pop,
	output tga_head_t head,
	output logic      room
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W:0] ROOM_MAX = (PTR_W + 1)'(DEPTH - 2);

	tga_item_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [PTR_W:0]   cnt_q;

	assign wr_nx      = wr_q + PTR_W'(1);
	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rd_q];
	assign room       = (cnt_q <= ROOM_MAX);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_q] <= push.i0;
		end
		if (push.v1) begin
			entry_q[wr_nx] <= push.i1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.v0) + PTR_W'(push.v1);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + (PTR_W + 1)'(push.v0) + (PTR_W + 1)'(push.v1) -
				(PTR_W + 1)'(pop);
		end
	end

endmodule

>>> rtl/tga_back.sv
// ----------------------------------------------------------------------------
// tga_back
// Position unit and output register. Stamps each pixel run with its start
// column and destination row, then advances the position. Runs that wrap
// more than one row go through a bit-serial divider by the image width.
// ----------------------------------------------------------------------------
module tga_back import tga_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  tga_head_t       head,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output tga_result_req_t result_req
);

	localparam int unsigned CNT_W = $clog2(RUN_W);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RUN_W - 1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_DIV  = 2'b10
	} tga_back_state_t;

	tga_back_state_t state_q;
	logic            out_v_q;
	tga_result_req_t out_q, res_d;
	logic [15:0]     col_q, row_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RUN_W-1:0] num_q, den_q, rem_q, quo_q, rem_nx, quo_nx;
	logic [RUN_W:0]   cand, cand_sub;
	logic             ge;
	logic [16:0]      pos, wid, pos_wrap;
	logic             is_run, fast0, fast1;

	assign result_valid = out_v_q;
	assign result_req   = out_q;
	assign pop = head.valid && (state_q == BK_IDLE) && (!out_v_q || !result_stall);

	assign is_run   = (head.item.status == STAT_RUN);
	assign pos      = {1'b0, col_q} + 17'(head.item.run);
	assign wid      = {1'b0, head.item.width};
	assign pos_wrap = pos - wid;
	assign fast0    = pos < wid;
	assign fast1    = pos_wrap < wid;

	assign cand     = {rem_q, num_q[RUN_W-1]};
	assign ge       = cand >= {1'b0, den_q};
	assign cand_sub = cand - {1'b0, den_q};
	assign rem_nx   = ge ? cand_sub[RUN_W-1:0] : cand[RUN_W-1:0];
	assign quo_nx   = {quo_q[RUN_W-2:0], ge};

	always_comb begin
		res_d.status         = head.item.status;
		res_d.pixel_value    = head.item.pixel;
		res_d.run_count      = head.item.run;
		res_d.image_type     = head.item.img_type;
		res_d.bits_per_pixel = head.item.depth;
		res_d.image_width    = head.item.width;
		res_d.image_height   = head.item.height;
		res_d.start_column   = 16'd0;
		res_d.start_row      = 16'd0;
		if (is_run) begin
			res_d.start_column = col_q;
			res_d.start_row    = head.item.flip ? (head.item.height - 16'd1 - row_q) : row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_d;
		end
		if (state_q == BK_IDLE) begin
			num_q <= pos[RUN_W-1:0];
			den_q <= head.item.width[RUN_W-1:0];
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			num_q <= {num_q[RUN_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
			col_q   <= 16'd0;
			row_q   <= 16'd0;
			cnt_q   <= '0;
		end else begin
			if (pop) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					cnt_q <= '0;
					if (pop && head.item.status == STAT_HDR_OK) begin
						col_q <= 16'd0;
						row_q <= 16'd0;
					end else if (pop && is_run) begin
						if (fast0) begin
							col_q <= pos[15:0];
						end else if (fast1) begin
							col_q <= pos_wrap[15:0];
							row_q <= row_q + 16'd1;
						end else begin
							state_q <= BK_DIV;
						end
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						row_q   <= row_q + 16'(quo_nx);
						col_q   <= 16'(rem_nx);
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/tga_checker.sv
// ----------------------------------------------------------------------------
// tga_checker
// Port-level checks on the decoder's byte input and result stream.
// ----------------------------------------------------------------------------
module tga_checker import tga_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            file_valid,
	input logic            file_stall,
	input tga_byte_req_t   file_req,
	input logic            result_valid,
	input logic            result_stall,
	input tga_result_req_t result_req
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_req))
		else $error("result request changed while stalled");

	a_column_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_req.status == STAT_RUN |->
		result_req.start_column < result_req.image_width)
		else $error("run starts beyond image width");

	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_req.status == STAT_RUN |->
		result_req.start_row < result_req.image_height)
		else $error("run starts beyond image height");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_req.status != STAT_RUN |->
		result_req.pixel_value == 32'd0 && result_req.run_count == '0 &&
		result_req.start_column == 16'd0 && result_req.start_row == 16'd0)
		else $error("status request carries pixel fields");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		file_valid && file_stall |=> $stable(file_req) || !file_valid)
		else $error("byte request changed while stalled");

endmodule

bind tga_image_stream_decoder tga_checker u_tga_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.file_valid   (file_valid),
	.file_stall   (file_stall),
	.file_req     (file_req),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_req   (result_req)
);
